>>> hdl/pcicfg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared types and constants of the PCI configuration space with BAR sizing.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

    localparam logic [15:0] VENDOR_ID  = 16'h1234;
    localparam logic [15:0] DEVICE_ID  = 16'h5678;
    localparam logic [31:0] ID_WORD    = {DEVICE_ID, VENDOR_ID};
    localparam logic [31:0] CLASS_WORD = 32'h0200_0001;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] IO_FLAGS   = 32'h0000_0003;
    localparam logic [31:0] MEM_FLAGS  = 32'h0000_000F;

    localparam logic [7:0] ID_INDEX    = 8'd0;
    localparam logic [7:0] CLASS_INDEX = 8'd2;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 36;
    localparam int SIZE_CODE_W = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FUNCTION_ADDRESS = 2'd0,
        CFG_FUNCTION_PRESENT = 2'd1,
        CFG_BAR_IMPLEMENTED  = 2'd2,
        CFG_BAR_SIZE_CODES   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    function automatic logic [31:0] reset_word(input logic [7:0] index);
        logic [31:0] word;
        word = '0;
        if (index == ID_INDEX) begin
            word = ID_WORD;
        end else if (index == CLASS_INDEX) begin
            word = CLASS_WORD;
        end
        return word;
    endfunction

endpackage
`default_nettype wire

>>> hdl/pcicfg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_ctrl
// Request sequencer: accept, execute against the register state, present.
// ----------------------------------------------------------------------------
module pcicfg_ctrl
    import pcicfg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    output logic         o_m_valid,
    input  wire logic    i_m_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_ready   = (r_state == S_IDLE) || ((r_state == S_RESP) && i_m_ready);
    assign accept      = i_s_valid && o_s_ready;
    assign o_m_valid   = (r_state == S_RESP);
    assign o_cmd.capture = accept;
    assign o_cmd.execute = (r_state == S_EXEC);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (accept) begin
                    n_state = S_EXEC;
                end else if (i_m_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute)
        else $error("capture not followed by execute");

    a_exec_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> o_m_valid)
        else $error("execute not followed by response");

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> !o_s_ready)
        else $error("request accepted while executing");

    a_overlap_needs_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && o_s_ready) |-> i_m_ready)
        else $error("request accepted over a pending response");

endmodule
`default_nettype wire

>>> hdl/pcicfg_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_datapath
// Configuration registers, BAR state, dword store and response register.
// ----------------------------------------------------------------------------
module pcicfg_datapath
    import pcicfg_pkg::*;
#(
    parameter int CONFIG_DWORDS   = 64,
    parameter int BAR_COUNT       = 6,
    parameter int FIRST_BAR_INDEX = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic                   i_func,
    input  wire logic [23:0]            i_target_address,
    input  wire logic [7:0]             i_reg_index,
    input  wire logic [31:0]            i_write_data,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [31:0]                 o_read_data,
    output logic                        o_status
);

    localparam int MemDepth = (CONFIG_DWORDS < 256) ? CONFIG_DWORDS : 256;
    localparam int MEM_AW   = $clog2(MemDepth);
    localparam int SLOT_W   = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
    localparam logic [8:0]  BAR_LO    = 9'(FIRST_BAR_INDEX);
    localparam logic [8:0]  BAR_HI    = 9'(FIRST_BAR_INDEX + BAR_COUNT);
    localparam logic [10:0] STORE_END = 11'(CONFIG_DWORDS);

    logic [23:0]         r_function_address;
    logic                r_function_present;
    logic [5:0]          r_bar_implemented;
    logic [35:0]         r_bar_size_codes;

    logic                r_func;
    logic [23:0]         r_target;
    logic [7:0]          r_reg;
    logic [31:0]         r_wdata;

    logic [31:0]         r_mem [0:MemDepth-1];
    logic [31:0]         r_mem_q;
    logic [MemDepth-1:0] r_valid;

    logic [31:0]         r_bar_value [0:BAR_COUNT-1];
    logic [BAR_COUNT-1:0] r_bar_probing;

    logic [31:0]         r_read_data;
    logic                r_status;

    logic                match;
    logic                is_bar;
    logic                in_store;
    logic [SLOT_W-1:0]   slot;
    logic [7:0]          slot_full;
    logic                bar_present;
    logic [SIZE_CODE_W-1:0] code;
    logic [SIZE_CODE_W-1:0] code_less_one;
    logic [31:0]         size_mask;
    logic [31:0]         bar_val;
    logic [31:0]         probe;
    logic [MEM_AW-1:0]   mem_addr;
    logic                bar_write;
    logic                store_write;
    logic [31:0]         n_read_data;
    logic                n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_address <= 24'h00_0800;
            r_function_present <= 1'b1;
            r_bar_implemented  <= 6'd1;
            r_bar_size_codes   <= 36'd13;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FUNCTION_ADDRESS: r_function_address <= i_cfg_data[23:0];
                CFG_FUNCTION_PRESENT: r_function_present <= i_cfg_data[0];
                CFG_BAR_IMPLEMENTED:  r_bar_implemented  <= i_cfg_data[5:0];
                CFG_BAR_SIZE_CODES:   r_bar_size_codes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_target <= i_target_address;
            r_reg    <= i_reg_index;
            r_wdata  <= i_write_data;
        end
    end

    assign match     = r_function_present && (r_target == r_function_address);
    assign is_bar    = ({1'b0, r_reg} >= BAR_LO) && ({1'b0, r_reg} < BAR_HI);
    assign in_store  = ({3'b000, r_reg} < STORE_END);
    assign slot_full = r_reg - BAR_LO[7:0];
    assign slot      = slot_full[SLOT_W-1:0];
    assign mem_addr  = r_reg[MEM_AW-1:0];

    assign bar_present   = r_bar_implemented[slot];
    assign bar_val       = r_bar_value[slot];
    assign code          = r_bar_size_codes[SIZE_CODE_W*int'(slot) +: SIZE_CODE_W];
    assign code_less_one = code - SIZE_CODE_W'(1);

    always_comb begin
        if (code > SIZE_CODE_W'(32)) begin
            size_mask = '0;
        end else begin
            size_mask = ALL_ONES << code_less_one;
        end
        if (code == '0) begin
            probe = '0;
        end else if (bar_val[0]) begin
            probe = (size_mask & ~IO_FLAGS) | (bar_val & IO_FLAGS);
        end else begin
            probe = (size_mask & ~MEM_FLAGS) | (bar_val & MEM_FLAGS);
        end
    end

    assign bar_write   = i_cmd.execute && match && is_bar && (r_func == FUNC_WRITE)
                         && bar_present;
    assign store_write = i_cmd.execute && match && !is_bar && in_store
                         && (r_func == FUNC_WRITE);

    always_comb begin
        n_read_data = '0;
        n_status    = STATUS_OK;
        if (!match) begin
            n_read_data = (r_func == FUNC_WRITE) ? 32'd0 : ALL_ONES;
        end else if (is_bar) begin
            if ((r_func == FUNC_READ) && bar_present) begin
                n_read_data = r_bar_probing[slot] ? probe : bar_val;
            end
        end else if (!in_store) begin
            n_status = STATUS_BAD_INDEX;
        end else if (r_func == FUNC_READ) begin
            n_read_data = r_valid[mem_addr] ? r_mem_q : reset_word(8'(mem_addr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_write) begin
            r_mem[mem_addr] <= r_wdata;
        end
        if (i_cmd.capture) begin
            r_mem_q <= r_mem[i_reg_index[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (store_write) begin
            r_valid[mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_probing <= '0;
            for (int i = 0; i < BAR_COUNT; i++) begin
                r_bar_value[i] <= '0;
            end
        end else if (bar_write) begin
            if (r_wdata == ALL_ONES) begin
                r_bar_probing[slot] <= 1'b1;
            end else begin
                r_bar_probing[slot] <= 1'b0;
                r_bar_value[slot]   <= (r_wdata & ~MEM_FLAGS) | (bar_val & MEM_FLAGS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_read_data <= n_read_data;
            r_status    <= n_status;
        end
    end

    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule
`default_nettype wire

>>> hdl/pci_config_space_bar_sizing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pci_config_space_bar_sizing
// Type 0 configuration space of one PCI function with BAR size probing.
// ----------------------------------------------------------------------------
// Each request is one dword configuration read or write; each produces one
// response. A request is captured along with its registered store read, then
// executed, then its response is held until taken; the next request can be
// accepted in the cycle the response is taken, and no request is accepted
// while one is executing. Execution works on the registered read of the
// dword store. No reset sweep is needed: store entries never written read
// their reset value.
// ----------------------------------------------------------------------------
module pci_config_space_bar_sizing
    import pcicfg_pkg::*;
#(
    parameter int CONFIG_DWORDS   = 64,
    parameter int BAR_COUNT       = 6,
    parameter int FIRST_BAR_INDEX = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [63:0]            i_s_axis_tdata,  // target_address, reg_index, write_data
    input  wire logic                   i_s_axis_tuser,  // func
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,  // read_data
    output logic                        o_m_axis_tuser,  // status
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;

    pcicfg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd)
    );

    pcicfg_datapath #(
        .CONFIG_DWORDS   (CONFIG_DWORDS),
        .BAR_COUNT       (BAR_COUNT),
        .FIRST_BAR_INDEX (FIRST_BAR_INDEX)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_s_axis_tuser),
        .i_target_address (i_s_axis_tdata[23:0]),
        .i_reg_index      (i_s_axis_tdata[31:24]),
        .i_write_data     (i_s_axis_tdata[63:32]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_read_data      (o_m_axis_tdata),
        .o_status         (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCI type 0 configuration space with BAR sizing.
// ----------------------------------------------------------------------------
// Configuration read and write requests go in on the slave stream. A local
// copy of the register store, the BAR values and the probe flags computes
// each expected response, and every response is compared in order. The run
// covers the reset contents, function decode, BAR size probing across size
// codes, the store range limit and random traffic under several register
// settings. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import pcicfg_pkg::*;

    localparam int CONFIG_DWORDS   = 64;
    localparam int BAR_COUNT       = 6;
    localparam int FIRST_BAR_INDEX = 4;
    localparam int MAX_IDLE        = 18;
    localparam int STALL_LIMIT     = 2000;

    typedef struct {
        logic [31:0] read_data;
        logic        status;
    } t_response;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [63:0]            i_s_axis_tdata = '0;  // target_address, reg_index, write_data
    logic                   i_s_axis_tuser = 1'b0;  // func
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [31:0]            o_m_axis_tdata;  // read_data
    logic                   o_m_axis_tuser;  // status
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic [23:0]            fn_addr;
    logic                   fn_present;
    logic [5:0]             bar_impl;
    logic [35:0]            bar_sizes;
    logic [31:0]            cfg_words [CONFIG_DWORDS];
    logic [31:0]            bar_val [BAR_COUNT];
    logic                   bar_probe [BAR_COUNT];

    t_response              pending_responses [$];
    int                     mismatch_count = 0;
    bit                     idle_enabled = 1'b1;

    pci_config_space_bar_sizing #(
        .CONFIG_DWORDS   (CONFIG_DWORDS),
        .BAR_COUNT       (BAR_COUNT),
        .FIRST_BAR_INDEX (FIRST_BAR_INDEX)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void reset_space();
        fn_addr    = 24'h000800;
        fn_present = 1'b1;
        bar_impl   = 6'd1;
        bar_sizes  = 36'd13;
        foreach (cfg_words[i]) cfg_words[i] = '0;
        cfg_words[ID_INDEX]    = ID_WORD;
        cfg_words[CLASS_INDEX] = CLASS_WORD;
        foreach (bar_val[i]) begin
            bar_val[i]   = '0;
            bar_probe[i] = 1'b0;
        end
    endfunction

    function automatic logic [31:0] bar_probe_word(int slot);
        logic [5:0]  code;
        logic [63:0] span_less_one;
        logic [31:0] addr_mask;
        logic [31:0] val;
        code = bar_sizes[6*slot +: 6];
        val  = bar_val[slot];
        if (code == 6'd0) return '0;
        span_less_one = (64'd1 << (code - 6'd1)) - 64'd1;
        addr_mask = (code >= 6'd33) ? 32'd0 : ~span_less_one[31:0];
        if (val[0]) return (addr_mask & ~IO_FLAGS) | (val & IO_FLAGS);
        return (addr_mask & ~MEM_FLAGS) | (val & MEM_FLAGS);
    endfunction

    function automatic t_response cfg_space_access(logic func, logic [23:0] target,
                                                   logic [7:0] idx, logic [31:0] data);
        t_response rsp;
        int        slot;
        rsp.read_data = '0;
        rsp.status    = STATUS_OK;
        if (!fn_present || target != fn_addr) begin
            rsp.read_data = (func == FUNC_WRITE) ? 32'd0 : ALL_ONES;
        end else if (idx >= FIRST_BAR_INDEX && idx < FIRST_BAR_INDEX + BAR_COUNT) begin
            slot = idx - FIRST_BAR_INDEX;
            if (bar_impl[slot]) begin
                if (func == FUNC_WRITE) begin
                    if (data == ALL_ONES) begin
                        bar_probe[slot] = 1'b1;
                    end else begin
                        bar_probe[slot] = 1'b0;
                        bar_val[slot] = (data & ~MEM_FLAGS) | (bar_val[slot] & MEM_FLAGS);
                    end
                end else begin
                    rsp.read_data = bar_probe[slot] ? bar_probe_word(slot) : bar_val[slot];
                end
            end
        end else if (idx >= CONFIG_DWORDS) begin
            rsp.status = STATUS_BAD_INDEX;
        end else if (func == FUNC_WRITE) begin
            cfg_words[idx] = data;
        end else begin
            rsp.read_data = cfg_words[idx];
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(logic func, logic [23:0] target, logic [7:0] idx,
                                logic [31:0] data);
        int gap;
        gap = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {data, idx, target};
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_responses.push_back(cfg_space_access(func, target, idx, data));
    endtask

    // drop the request valid and let the block settle with nothing in flight
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_index idx, logic [35:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_FUNCTION_ADDRESS: fn_addr    = value[23:0];
            CFG_FUNCTION_PRESENT: fn_present = value[0];
            CFG_BAR_IMPLEMENTED:  bar_impl   = value[5:0];
            CFG_BAR_SIZE_CODES:   bar_sizes  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [35:0] random_size_codes();
        logic [35:0] codes;
        for (int i = 0; i < BAR_COUNT; i++) begin
            case ($urandom_range(0, 7))
                0: codes[6*i +: 6] = 6'd0;
                1: codes[6*i +: 6] = 6'd1;
                2: codes[6*i +: 6] = 6'd32;
                3: codes[6*i +: 6] = 6'd33;
                4: codes[6*i +: 6] = 6'd63;
                default: codes[6*i +: 6] = 6'($urandom_range(2, 31));
            endcase
        end
        return codes;
    endfunction

    task automatic test_reset_state();
        send_request(FUNC_READ, fn_addr, ID_INDEX, $urandom());
        send_request(FUNC_READ, fn_addr, CLASS_INDEX, $urandom());
        send_request(FUNC_READ, fn_addr, 8'(FIRST_BAR_INDEX), $urandom());
        send_request(FUNC_READ, fn_addr, 8'(FIRST_BAR_INDEX + 1), $urandom());
        send_request(FUNC_READ, fn_addr, 8'(CONFIG_DWORDS), $urandom());
        send_request(FUNC_READ, fn_addr, 8'hFF, $urandom());
    endtask

    task automatic test_function_match();
        send_request(FUNC_READ, ~fn_addr, ID_INDEX, $urandom());
        send_request(FUNC_WRITE, ~fn_addr, 8'd200, $urandom());
        send_request(FUNC_WRITE, fn_addr ^ 24'h000001, 8'd1, $urandom());
        send_request(FUNC_READ, fn_addr, 8'd1, $urandom());
        wait_idle();
        write_cfg(CFG_FUNCTION_PRESENT, 36'hF_FFFF_FFFE);
        send_request(FUNC_READ, fn_addr, ID_INDEX, $urandom());
        wait_idle();
        write_cfg(CFG_FUNCTION_PRESENT, 36'd1);
    endtask

    task automatic test_bar_probing();
        send_request(FUNC_WRITE, fn_addr, 8'(FIRST_BAR_INDEX), ALL_ONES);
        send_request(FUNC_READ, fn_addr, 8'(FIRST_BAR_INDEX), $urandom());
        send_request(FUNC_WRITE, fn_addr, 8'(FIRST_BAR_INDEX), 32'h89AB_CDEF);
        send_request(FUNC_READ, fn_addr, 8'(FIRST_BAR_INDEX), $urandom());
        wait_idle();
        write_cfg(CFG_BAR_IMPLEMENTED, 36'hF_FFFF_FFFF);
        write_cfg(CFG_BAR_SIZE_CODES, {6'd13, 6'd63, 6'd33, 6'd32, 6'd1, 6'd0});
        foreach (bar_val[slot]) begin
            if (slot == 2 || slot == 5) continue;
            send_request(FUNC_WRITE, fn_addr, 8'(FIRST_BAR_INDEX + slot), ALL_ONES);
            send_request(FUNC_READ, fn_addr, 8'(FIRST_BAR_INDEX + slot), $urandom());
        end
    endtask

    task automatic test_store_range();
        send_request(FUNC_WRITE, fn_addr, 8'(CONFIG_DWORDS - 1), $urandom());
        send_request(FUNC_READ, fn_addr, 8'(CONFIG_DWORDS - 1), $urandom());
        send_request(FUNC_WRITE, fn_addr, 8'(CONFIG_DWORDS), $urandom());
    endtask

    task automatic configure_phase(int phase);
        wait_idle();
        case (phase)
            0: begin
                write_cfg(CFG_FUNCTION_ADDRESS, {12'($urandom()), 24'($urandom())});
                write_cfg(CFG_BAR_IMPLEMENTED, 36'($urandom_range(0, 63)));
                write_cfg(CFG_BAR_SIZE_CODES, random_size_codes());
            end
            1: begin
                write_cfg(CFG_FUNCTION_ADDRESS, 36'h0_00FF_FFFF);
                write_cfg(CFG_BAR_IMPLEMENTED, 36'd63);
                write_cfg(CFG_BAR_SIZE_CODES, random_size_codes());
            end
            2: begin
                write_cfg(CFG_FUNCTION_ADDRESS, 36'hF_FF00_0000);
                write_cfg(CFG_BAR_IMPLEMENTED, 36'd63);
                write_cfg(CFG_BAR_SIZE_CODES, 36'hF_FFFF_FFFF);
            end
            3: begin
                write_cfg(CFG_FUNCTION_ADDRESS, 36'($urandom()));
                write_cfg(CFG_BAR_IMPLEMENTED, 36'd63);
                write_cfg(CFG_BAR_SIZE_CODES, 36'd0);
            end
            default: begin
                write_cfg(CFG_FUNCTION_ADDRESS, 36'($urandom()));
                write_cfg(CFG_BAR_IMPLEMENTED, 36'd0);
                write_cfg(CFG_BAR_SIZE_CODES, random_size_codes());
            end
        endcase
        write_cfg(CFG_FUNCTION_PRESENT, {35'($urandom()), 1'b1});
        idle_enabled = (phase != 1);
    endtask

    task automatic test_random_traffic();
        logic        func;
        logic [23:0] target;
        logic [7:0]  idx;
        logic [31:0] data;
        bit          is_bar;
        for (int phase = 0; phase < 5; phase++) begin
            configure_phase(phase);
            repeat ((phase == 4) ? 100 : 200) begin
                target = ($urandom_range(0, 99) < 85) ? fn_addr : 24'($urandom());
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7:
                        idx = 8'($urandom_range(FIRST_BAR_INDEX,
                                                FIRST_BAR_INDEX + BAR_COUNT - 1));
                    17, 18, 19: idx = 8'($urandom_range(0, 255));
                    default:    idx = 8'($urandom_range(0, CONFIG_DWORDS - 1));
                endcase
                func   = 1'($urandom_range(0, 1));
                is_bar = idx >= FIRST_BAR_INDEX && idx < FIRST_BAR_INDEX + BAR_COUNT;
                data   = (is_bar && $urandom_range(0, 9) < 4) ? ALL_ONES : $urandom();
                send_request(func, target, idx, data);
            end
        end
        idle_enabled = 1'b1;
    endtask

    // take responses and compare them with the oldest pending request
    initial begin
        t_response want;
        int        stall;
        wait (i_rst_n);
        forever begin
            stall = idle_enabled ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            if (pending_responses.size() == 0) begin
                report_mismatch("unrequested response", o_m_axis_tdata, 32'd0);
            end else begin
                want = pending_responses.pop_front();
                if (o_m_axis_tdata !== want.read_data) begin
                    report_mismatch("read_data", o_m_axis_tdata, want.read_data);
                end
                if (o_m_axis_tuser !== want.status) begin
                    report_mismatch("status", 32'(o_m_axis_tuser), 32'(want.status));
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        reset_space();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_function_match();
        test_bar_probing();
        test_store_range();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_responses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
